### sv/dxt1_dxt5_block_decoder_assert.svh
// Assertion macros for the DXT1/DXT5 block decoder checker.
`ifndef DXT1_DXT5_BLOCK_DECODER_ASSERT_SVH
`define DXT1_DXT5_BLOCK_DECODER_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define DXTBD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define DXTBD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### sv/dxtbd_pkg.sv
// Package: shared types, constants and constant-division helpers of the block decoder.
`default_nettype none
package dxtbd_pkg;

    localparam int COORD_BITS = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd2;

    // reciprocals for truncating division by small constants
    localparam int RECIP_31 = 8457;   // 2^18 / 31, rounded up
    localparam int RECIP_63 = 16645;  // 2^20 / 63, rounded up
    localparam int RECIP_3  = 683;    // 2^11 / 3, rounded up
    localparam int RECIP_7  = 2341;   // 2^14 / 7, rounded up
    localparam int RECIP_5  = 1639;   // 2^13 / 5, rounded up

    typedef struct packed {
        logic [3:0][31:0] color;
        logic [7:0][7:0]  alpha;
    } t_palette;

    typedef struct packed {
        logic [15:0]      y;
        logic [15:0]      x;
        logic [3:0][31:0] pix;
        logic [3:0]       mask;
        logic             last;
    } t_row;

    // v * 255 / 31
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [12:0] x;
        logic [26:0] prod;
        x    = {v, 8'b0} - 13'(v);
        prod = 27'(x) * 27'(RECIP_31);
        return prod[25:18];
    endfunction

    // v * 255 / 63
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [13:0] x;
        logic [28:0] prod;
        x    = {v, 8'b0} - 14'(v);
        prod = 29'(x) * 29'(RECIP_63);
        return prod[27:20];
    endfunction

    // x / 3, x <= 765
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'(RECIP_3);
        return prod[18:11];
    endfunction

    // x / 7, x <= 1785
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'(RECIP_7);
        return prod[21:14];
    endfunction

    // x / 5, x <= 1275
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] prod;
        prod = 22'(x) * 22'(RECIP_5);
        return prod[20:13];
    endfunction

endpackage
`default_nettype wire

### sv/dxtbd_palette.sv
// Color and alpha palette construction for one compressed block.
`default_nettype none
module dxtbd_palette import dxtbd_pkg::*; (
    input  logic [63:0] i_alpha_word,
    input  logic [63:0] i_color_word,
    input  logic        i_dxt5,
    output t_palette    o_pal
);

    always_comb begin
        logic [15:0]     c0;
        logic [15:0]     c1;
        logic [2:0][7:0] e0;
        logic [2:0][7:0] e1;
        logic [2:0][7:0] m2;
        logic [2:0][7:0] m3;
        logic [8:0]      sum;
        logic            four;
        logic [7:0]      a0;
        logic [7:0]      a1;

        c0 = i_color_word[15:0];
        c1 = i_color_word[31:16];
        e0[0] = expand5(c0[15:11]);
        e0[1] = expand6(c0[10:5]);
        e0[2] = expand5(c0[4:0]);
        e1[0] = expand5(c1[15:11]);
        e1[1] = expand6(c1[10:5]);
        e1[2] = expand5(c1[4:0]);
        four  = i_dxt5 || (c0 > c1);

        for (int ch = 0; ch < 3; ch++) begin
            sum = 9'(e0[ch]) + 9'(e1[ch]);
            if (four) begin
                m2[ch] = div3({e0[ch], 1'b0} + 10'(e1[ch]));
                m3[ch] = div3(10'(e0[ch]) + {e1[ch], 1'b0});
            end else begin
                m2[ch] = sum[8:1];
                m3[ch] = 8'd0;
            end
        end

        o_pal.color[0] = {8'hff, e0[2], e0[1], e0[0]};
        o_pal.color[1] = {8'hff, e1[2], e1[1], e1[0]};
        o_pal.color[2] = {8'hff, m2[2], m2[1], m2[0]};
        o_pal.color[3] = four ? {8'hff, m3[2], m3[1], m3[0]} : 32'h0;

        a0 = i_alpha_word[7:0];
        a1 = i_alpha_word[15:8];
        o_pal.alpha[0] = a0;
        o_pal.alpha[1] = a1;
        for (int i = 2; i < 8; i++) begin
            if (a0 > a1) begin
                o_pal.alpha[i] = div7(11'((8 - i) * a0 + (i - 1) * a1));
            end else if (i < 6) begin
                o_pal.alpha[i] = div5(11'((6 - i) * a0 + (i - 1) * a1));
            end else if (i == 6) begin
                o_pal.alpha[i] = 8'd0;
            end else begin
                o_pal.alpha[i] = 8'hff;
            end
        end
    end

endmodule
`default_nettype wire

### sv/dxtbd_row_sel.sv
// Row pixel lookup, coordinates and clip mask for one row of a block.
`default_nettype none
module dxtbd_row_sel import dxtbd_pkg::*; (
    input  t_palette              i_pal,
    input  logic [31:0]           i_cidx,
    input  logic [47:0]           i_aidx,
    input  logic                  i_dxt5,
    input  logic [1:0]            i_row,
    input  logic [COORD_BITS-1:0] i_x0,
    input  logic [13:0]           i_by,
    input  logic [15:0]           i_width,
    input  logic [15:0]           i_height,
    output t_row                  o_row
);

    always_comb begin
        logic [7:0]               crow;
        logic [11:0]              arow;
        logic [COORD_BITS+15:0]   ywide;
        logic [COORD_BITS-1:0]    y;
        logic [COORD_BITS-1:0]    xc;
        logic [COORD_BITS+15:0]   ox;
        logic [COORD_BITS+15:0]   oy;
        logic                     y_in;

        unique case (i_row)
            2'd0: begin
                crow = i_cidx[7:0];
                arow = i_aidx[11:0];
            end
            2'd1: begin
                crow = i_cidx[15:8];
                arow = i_aidx[23:12];
            end
            2'd2: begin
                crow = i_cidx[23:16];
                arow = i_aidx[35:24];
            end
            default: begin
                crow = i_cidx[31:24];
                arow = i_aidx[47:36];
            end
        endcase

        ywide = {{COORD_BITS{1'b0}}, i_by, i_row};
        y     = ywide[COORD_BITS-1:0];
        y_in  = ({16'b0, y} < {{COORD_BITS{1'b0}}, i_height});

        for (int c = 0; c < 4; c++) begin
            o_row.pix[c] = i_pal.color[crow[2*c +: 2]];
            if (i_dxt5) begin
                o_row.pix[c][31:24] = i_pal.alpha[arow[3*c +: 3]];
            end
            xc = i_x0 + COORD_BITS'(c);
            o_row.mask[c] = y_in && ({16'b0, xc} < {{COORD_BITS{1'b0}}, i_width});
        end

        ox = {16'b0, i_x0};
        oy = {16'b0, y};
        o_row.x    = ox[15:0];
        o_row.y    = oy[15:0];
        o_row.last = (i_row == 2'd3);
    end

endmodule
`default_nettype wire

### sv/dxt1_dxt5_block_decoder.sv
// Top level: DXT1/DXT5 4x4 block decoder emitting one RGBA8 pixel row per cycle.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  block in | start & !busy      | i_alpha_word, i_color_word, i_block_column/line
//  row out  | o_valid (1 cycle)  | o_pixel_y/x, o_pixels_*_pair, o_write_mask, o_last_row
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// The row stage emits one row per cycle.
// From accept to the first row an item passes the input, palette and row registers.
// The next item is taken while the current one is still emitting rows.
// Reset is synchronous, active low; busy is high while in reset.
// Rows cannot be stalled: each sits on the outputs for one cycle.
`default_nettype none
module dxt1_dxt5_block_decoder import dxtbd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [63:0]               i_alpha_word,
    input  logic [63:0]               i_color_word,
    input  logic [13:0]               i_block_column,
    input  logic [13:0]               i_block_line,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                      o_valid,
    output logic [15:0]               o_pixel_y,
    output logic [15:0]               o_pixel_x,
    output logic [63:0]               o_pixels_first_pair,
    output logic [63:0]               o_pixels_second_pair,
    output logic [3:0]                o_write_mask,
    output logic                      o_last_row
);

    logic        r_fmt;
    logic [15:0] r_width;
    logic [15:0] r_height;

    logic        r_in_vld, n_in_vld;
    logic [63:0] r_aw;
    logic [63:0] r_cw;
    logic [13:0] r_bx;
    logic [13:0] r_by;

    logic                  r_pal_vld, n_pal_vld;
    logic [1:0]            r_row, n_row;
    t_palette              r_pal;
    logic [31:0]           r_cidx;
    logic [47:0]           r_aidx;
    logic                  r_dxt5;
    logic [COORD_BITS-1:0] r_x0;
    logic [13:0]           r_pby;

    logic r_out_vld;
    t_row r_out;

    t_palette               pal;
    t_row                   row;
    logic                   accept;
    logic                   pal_done;
    logic                   pal_load;
    logic [COORD_BITS+15:0] xwide;

    assign pal_done = r_pal_vld && (r_row == 2'd3);
    assign pal_load = r_in_vld && (!r_pal_vld || pal_done);
    assign busy     = !i_rst_n || (r_in_vld && !pal_load);
    assign accept   = start && !busy;
    assign xwide    = {{COORD_BITS{1'b0}}, r_bx, 2'b00};

    always_comb begin
        n_in_vld = r_in_vld;
        if (accept) begin
            n_in_vld = 1'b1;
        end else if (pal_load) begin
            n_in_vld = 1'b0;
        end
        n_pal_vld = r_pal_vld;
        n_row     = r_row;
        if (pal_load) begin
            n_pal_vld = 1'b1;
            n_row     = 2'd0;
        end else if (r_pal_vld) begin
            n_pal_vld = !pal_done;
            n_row     = r_row + 2'd1;
        end
    end

    dxtbd_palette u_palette (
        .i_alpha_word (r_aw),
        .i_color_word (r_cw),
        .i_dxt5       (r_fmt),
        .o_pal        (pal)
    );

    dxtbd_row_sel u_row_sel (
        .i_pal    (r_pal),
        .i_cidx   (r_cidx),
        .i_aidx   (r_aidx),
        .i_dxt5   (r_dxt5),
        .i_row    (r_row),
        .i_x0     (r_x0),
        .i_by     (r_pby),
        .i_width  (r_width),
        .i_height (r_height),
        .o_row    (row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= 1'b0;
            r_width   <= 16'd1;
            r_height  <= 16'd1;
            r_in_vld  <= 1'b0;
            r_pal_vld <= 1'b0;
            r_row     <= 2'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FORMAT: r_fmt    <= i_cfg_data[0];
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_vld  <= n_in_vld;
            r_pal_vld <= n_pal_vld;
            r_row     <= n_row;
            r_out_vld <= r_pal_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_aw <= i_alpha_word;
            r_cw <= i_color_word;
            r_bx <= i_block_column;
            r_by <= i_block_line;
        end
        if (pal_load) begin
            r_pal  <= pal;
            r_cidx <= r_cw[63:32];
            r_aidx <= r_aw[63:16];
            r_dxt5 <= r_fmt;
            r_x0   <= xwide[COORD_BITS-1:0];
            r_pby  <= r_by;
        end
        r_out <= row;
    end

    assign o_valid              = r_out_vld;
    assign o_pixel_y            = r_out.y;
    assign o_pixel_x            = r_out.x;
    assign o_pixels_first_pair  = {r_out.pix[1], r_out.pix[0]};
    assign o_pixels_second_pair = {r_out.pix[3], r_out.pix[2]};
    assign o_write_mask         = r_out.mask;
    assign o_last_row           = r_out.last;

endmodule
`default_nettype wire

### sv/dxtbd_checker.sv
// Port-level checker for the block decoder row stream, bound to the top level.
`default_nettype none
`include "dxt1_dxt5_block_decoder_assert.svh"
module dxtbd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        o_last_row,
    input wire logic [15:0] o_pixel_x,
    input wire logic [15:0] o_pixel_y
);

    // rows of one item come out back to back
    `DXTBD_ASSERT_NXT(a_rows_contig, i_clk, i_rst_n, o_valid && !o_last_row, o_valid, "row gap inside item")

    // row number steps by one and column stays within an item
    `DXTBD_ASSERT_NXT(a_row_step, i_clk, i_rst_n, o_valid && !o_last_row, (o_pixel_y[1:0] == $past(o_pixel_y[1:0]) + 2'd1) && (o_pixel_x == $past(o_pixel_x)), "row step broken")

    // the last row is the fourth row of the block
    `DXTBD_ASSERT_IMP(a_last_is_row3, i_clk, i_rst_n, o_valid && o_last_row, o_pixel_y[1:0] == 2'd3, "last row not row 3")

    // the last row follows three valid rows
    `DXTBD_ASSERT_IMP(a_last_after3, i_clk, i_rst_n, o_valid && o_last_row, $past(o_valid, 1) && $past(o_valid, 2) && $past(o_valid, 3), "last row without three rows")

endmodule

bind dxt1_dxt5_block_decoder dxtbd_checker u_dxtbd_checker (.*);
`default_nettype wire

### tb/sv/dxt1_dxt5_row_checker.sv
// Checker for the DXT1/DXT5 block decoder: predicts the four rows of each block and compares.
module dxt1_dxt5_row_checker import dxtbd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [63:0]               i_alpha_word,
    input  logic [63:0]               i_color_word,
    input  logic [13:0]               i_block_column,
    input  logic [13:0]               i_block_line,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      o_valid,
    input  logic [15:0]               o_pixel_y,
    input  logic [15:0]               o_pixel_x,
    input  logic [63:0]               o_pixels_first_pair,
    input  logic [63:0]               o_pixels_second_pair,
    input  logic [3:0]                o_write_mask,
    input  logic                      o_last_row,
    output int                        mismatches,
    output int                        rows_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] y;
        logic [15:0] x;
        logic [63:0] first_pair;
        logic [63:0] second_pair;
        logic [3:0]  mask;
        logic        last;
    } t_pixel_row;

    t_pixel_row  rows_due[$];
    logic        dxt5_mode;
    logic [15:0] width_px;
    logic [15:0] height_px;

    initial begin
        mismatches       = 0;
        rows_outstanding = 0;
    end

    // queue the four rows that one compressed block decodes to
    function automatic void decode_block(input logic [63:0] aw, input logic [63:0] cw,
                                         input logic [13:0] col, input logic [13:0] line);
        int          e0[3];
        int          e1[3];
        int          mid[3];
        int          apal[8];
        logic [31:0] cpal[4];
        logic [31:0] px[4];
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] x0;
        logic [15:0] y;
        logic [15:0] xc;
        logic [3:0]  mask;
        t_pixel_row  row;
        int          r;
        int          c;
        int          p;
        int          i;
        int          ch;
        c0 = cw[15:0];
        c1 = cw[31:16];
        e0[0] = int'(c0[15:11]) * 255 / 31;
        e0[1] = int'(c0[10:5]) * 255 / 63;
        e0[2] = int'(c0[4:0]) * 255 / 31;
        e1[0] = int'(c1[15:11]) * 255 / 31;
        e1[1] = int'(c1[10:5]) * 255 / 63;
        e1[2] = int'(c1[4:0]) * 255 / 31;
        cpal[0] = {8'hff, 8'(e0[2]), 8'(e0[1]), 8'(e0[0])};
        cpal[1] = {8'hff, 8'(e1[2]), 8'(e1[1]), 8'(e1[0])};
        if (dxt5_mode || c0 > c1) begin
            for (ch = 0; ch < 3; ch++) mid[ch] = (2 * e0[ch] + e1[ch]) / 3;
            cpal[2] = {8'hff, 8'(mid[2]), 8'(mid[1]), 8'(mid[0])};
            for (ch = 0; ch < 3; ch++) mid[ch] = (e0[ch] + 2 * e1[ch]) / 3;
            cpal[3] = {8'hff, 8'(mid[2]), 8'(mid[1]), 8'(mid[0])};
        end else begin
            for (ch = 0; ch < 3; ch++) mid[ch] = (e0[ch] + e1[ch]) / 2;
            cpal[2] = {8'hff, 8'(mid[2]), 8'(mid[1]), 8'(mid[0])};
            cpal[3] = 32'h0;
        end

        apal[0] = int'(aw[7:0]);
        apal[1] = int'(aw[15:8]);
        if (apal[0] > apal[1]) begin
            for (i = 2; i < 8; i++) apal[i] = ((8 - i) * apal[0] + (i - 1) * apal[1]) / 7;
        end else begin
            for (i = 2; i < 6; i++) apal[i] = ((6 - i) * apal[0] + (i - 1) * apal[1]) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        x0 = {col, 2'b00};
        for (r = 0; r < 4; r++) begin
            y    = {line, 2'b00} + 16'(r);
            mask = '0;
            for (c = 0; c < 4; c++) begin
                p     = r * 4 + c;
                px[c] = cpal[cw[32 + 2 * p +: 2]];
                if (dxt5_mode) px[c][31:24] = 8'(apal[aw[16 + 3 * p +: 3]]);
                xc = x0 + 16'(c);
                if (xc < width_px && y < height_px) mask[c] = 1'b1;
            end
            row.y           = y;
            row.x           = x0;
            row.first_pair  = {px[1], px[0]};
            row.second_pair = {px[3], px[2]};
            row.mask        = mask;
            row.last        = (r == 3);
            rows_due.push_back(row);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel_row want;
        logic       ok;
        if (!i_rst_n) begin
            dxt5_mode = 1'b0;
            width_px  = 16'd1;
            height_px = 16'd1;
            rows_due.delete();
        end else begin
            if (o_valid) begin
                if (rows_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: row with none due: y=%h x=%h", $realtime, o_pixel_y,
                                 o_pixel_x);
                end else begin
                    want = rows_due.pop_front();
                    ok = (o_pixel_y === want.y) && (o_pixel_x === want.x) &&
                         (o_pixels_first_pair === want.first_pair) &&
                         (o_pixels_second_pair === want.second_pair) &&
                         (o_write_mask === want.mask) && (o_last_row === want.last);
                    if (!ok) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: row mismatch", $realtime);
                            $display("  want y=%h x=%h p01=%h p23=%h mask=%b last=%b",
                                     want.y, want.x, want.first_pair, want.second_pair,
                                     want.mask, want.last);
                            $display("  got  y=%h x=%h p01=%h p23=%h mask=%b last=%b",
                                     o_pixel_y, o_pixel_x, o_pixels_first_pair,
                                     o_pixels_second_pair, o_write_mask, o_last_row);
                        end
                    end
                end
            end
            if (start && !busy)
                decode_block(i_alpha_word, i_color_word, i_block_column, i_block_line);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FORMAT: dxt5_mode = i_cfg_data[0];
                    REG_WIDTH:  width_px  = i_cfg_data;
                    REG_HEIGHT: height_px = i_cfg_data;
                    default: ;
                endcase
            end
        end
        rows_outstanding = rows_due.size();
    end

endmodule

### tb/sv/dxt1_dxt5_block_decoder_tb.sv
// Testbench top for the DXT1/DXT5 block decoder: clock, reset, block stimulus and verdict.
module dxt1_dxt5_block_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dxtbd_pkg::*;

    localparam logic                      FMT_DXT1        = 1'b0;
    localparam logic                      FMT_DXT5        = 1'b1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE       = 2'd3;
    localparam int                        WATCHDOG_LIMIT  = 2000;
    localparam int                        RANDOM_SEGMENTS = 12;
    localparam int                        SEGMENT_ITEMS   = 30;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [63:0]               i_alpha_word;
    logic [63:0]               i_color_word;
    logic [13:0]               i_block_column;
    logic [13:0]               i_block_line;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;
    logic                      o_valid;
    logic [15:0]               o_pixel_y;
    logic [15:0]               o_pixel_x;
    logic [63:0]               o_pixels_first_pair;
    logic [63:0]               o_pixels_second_pair;
    logic [3:0]                o_write_mask;
    logic                      o_last_row;
    int                        mismatches;
    int                        rows_outstanding;
    int                        sender_idle_pct;
    int                        quiet_cycles;

    dxt1_dxt5_block_decoder uut (.*);

    dxt1_dxt5_row_checker checker_i (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // called just after a falling edge; returns just after the falling edge past acceptance
    task automatic send_block(input logic [63:0] aw, input logic [63:0] cw,
                              input logic [13:0] col, input logic [13:0] line);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start          = 1'b1;
        i_alpha_word   = aw;
        i_color_word   = cw;
        i_block_column = col;
        i_block_line   = line;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        while (rows_outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic set_view(input logic fmt, input logic [15:0] w, input logic [15:0] h);
        drain();
        write_reg(REG_FORMAT, 16'(fmt));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    function automatic logic [15:0] pick_extent();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1, 2:    return 16'd1;
            3, 4:    return 16'hffff;
            5, 6, 7: return 16'($urandom_range(2, 64));
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // mostly near the clip edge so the write mask moves
    function automatic logic [13:0] pick_position(input logic [15:0] extent);
        int top;
        if ($urandom_range(0, 3) == 0) return 14'($urandom_range(0, 16383));
        top = int'(extent) / 4 + 1;
        if (top > 16383) top = 16383;
        return 14'($urandom_range(0, top));
    endfunction

    initial begin
        logic [63:0] aw;
        logic [63:0] cw;
        logic [15:0] w;
        logic [15:0] h;
        int          seg;
        int          n;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_alpha_word    = '0;
        i_color_word    = '0;
        i_block_column  = '0;
        i_block_line    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        sender_idle_pct = 11;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset view: DXT1, 1x1
        send_block({$urandom, $urandom}, 64'h0, 14'd0, 14'd0);

        // DXT1: four-color, three-color, transparent, ignored alpha, clipping
        set_view(FMT_DXT1, 16'd6, 16'd6);
        send_block(64'h0, {32'he4e4_e4e4, 16'h0000, 16'hffff}, 14'd1, 14'd1);
        send_block(64'hffff_ffff_ffff_ffff, {32'he4e4_e4e4, 16'hffff, 16'h0000}, 14'd0, 14'd1);
        send_block({$urandom, $urandom}, {32'hffff_ffff, 16'h8410, 16'h8410}, 14'd1, 14'd0);
        send_block(64'h0, 64'hffff_ffff_ffff_ffff, 14'd2, 14'd2);
        send_block({$urandom, $urandom}, {32'h1b1b_1b1b, 16'hf800, 16'h07e0},
                   14'd16383, 14'd16383);
        send_block({$urandom, $urandom}, {32'h4e4e_4e4e, 16'h001f, 16'hffe0}, 14'd0, 14'd0);

        // DXT5: eight- and six-entry alpha, equal endpoints, all indices
        set_view(FMT_DXT5, 16'd16, 16'd8);
        send_block({48'o7654321076543210, 8'h00, 8'hff}, {32'he4e4_e4e4, 16'h0000, 16'hffff},
                   14'd0, 14'd0);
        send_block({48'o0123456701234567, 8'hff, 8'h00}, {32'h1b1b_1b1b, 16'hffff, 16'h0000},
                   14'd1, 14'd0);
        send_block({48'o7654321076543210, 8'h80, 8'h80}, {32'he4e4_e4e4, 16'h8410, 16'h8410},
                   14'd3, 14'd1);
        send_block({48'o7777777777777777, 8'h00, 8'h00}, {$urandom, $urandom}, 14'd1, 14'd1);
        send_block(64'hffff_ffff_ffff_ffff, 64'h0, 14'd2, 14'd0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd4, 14'd2);

        // zero and full extents
        set_view(FMT_DXT5, 16'd0, 16'd0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd0, 14'd0);
        set_view(FMT_DXT1, 16'hffff, 16'hffff);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd16383, 14'd16383);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd0, 14'd0);
        set_view(FMT_DXT1, 16'hffff, 16'd0);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd0, 14'd0);
        set_view(FMT_DXT5, 16'd0, 16'hffff);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd0, 14'd0);

        // a write past the register list must change nothing
        drain();
        write_reg(REG_SPARE, 16'hffff);
        send_block({$urandom, $urandom}, {$urandom, $urandom}, 14'd5, 14'd5);

        for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            sender_idle_pct = (seg < 4) ? 11 : (seg < 8) ? 85 : 0;
            w = pick_extent();
            h = pick_extent();
            set_view(($urandom_range(0, 1) != 0) ? FMT_DXT5 : FMT_DXT1, w, h);
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                aw = {$urandom, $urandom};
                cw = {$urandom, $urandom};
                if ($urandom_range(0, 7) == 0) cw[31:16] = cw[15:0];
                if ($urandom_range(0, 7) == 0) aw[15:8] = aw[7:0];
                send_block(aw, cw, pick_position(w), pick_position(h));
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
